[design/spi_pkg.sv]
// shared types, constants and helpers for the softened pair interaction core
package spi_pkg;

  localparam int COORD_W = 24;
  localparam int OUT_W   = 48;
  localparam int SOFT_W  = 48;
  localparam int R2_W    = 50;
  localparam int SQ_IN_W = 62;
  localparam int S_W     = 31;
  localparam int R_W     = 57;
  localparam int R2P_W   = 114;
  localparam int R3_W    = 171;
  localparam int PROD_W  = 195;
  localparam int POT_W   = 81;

  localparam logic [SOFT_W-1:0] SOFT_RESET = 48'd281474977;
  localparam logic [OUT_W-1:0]  POS_MAX    = 48'h7FFF_FFFF_FFFF;
  localparam logic [OUT_W-1:0]  NEG_MAX    = 48'h8000_0000_0000;
  // remainder after the leading dividend bits of 2^62 above the quotient width
  localparam logic [31:0]       RECIP_REM0 = 32'd32;

  typedef struct packed {
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] first_z;
    logic [COORD_W-1:0] first_charge;
    logic [COORD_W-1:0] second_x;
    logic [COORD_W-1:0] second_y;
    logic [COORD_W-1:0] second_z;
    logic [COORD_W-1:0] second_charge;
  } pair_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] first_fx;
    logic signed [OUT_W-1:0] first_fy;
    logic signed [OUT_W-1:0] first_fz;
    logic signed [OUT_W-1:0] first_potential;
    logic signed [OUT_W-1:0] second_fx;
    logic signed [OUT_W-1:0] second_fy;
    logic signed [OUT_W-1:0] second_fz;
    logic signed [OUT_W-1:0] second_potential;
  } incr_t;

  // what travels alongside the distance arithmetic
  typedef struct packed {
    logic [2:0][COORD_W-1:0] mag;
    logic [2:0]              neg;
    logic [COORD_W-1:0]      q1;
    logic [COORD_W-1:0]      q2;
  } side_t;

  function automatic logic [OUT_W-1:0] sgn_out(input logic [OUT_W-1:0] m, input logic neg);
    logic [OUT_W-1:0] res;
    if (neg) begin
      res = OUT_W'(0) - m;
    end else begin
      res = (m > POS_MAX) ? POS_MAX : m;
    end
    return res;
  endfunction

endpackage

[design/spi_front.sv]
// differences, squares and softened squared distance
module spi_front import spi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  pair_t             in_data,
  input  logic [SOFT_W-1:0] eps_sq,
  output logic              out_valid,
  output logic [R2_W-1:0]   r2,
  output side_t             side
);

  logic                     v1;
  logic                     v2;
  side_t                    side1;
  side_t                    side2;
  logic [2*COORD_W-1:0]     sq [3];
  side_t                    side_next;
  logic [COORD_W-1:0]       pa [3];
  logic [COORD_W-1:0]       pb [3];
  logic [R2_W-1:0]          sum_next;

  always_comb begin
    pa[0] = in_data.first_x;
    pa[1] = in_data.first_y;
    pa[2] = in_data.first_z;
    pb[0] = in_data.second_x;
    pb[1] = in_data.second_y;
    pb[2] = in_data.second_z;
    side_next.q1 = in_data.first_charge;
    side_next.q2 = in_data.second_charge;
    for (int k = 0; k < 3; k++) begin
      side_next.neg[k] = pa[k] < pb[k];
      side_next.mag[k] = side_next.neg[k] ? (pb[k] - pa[k]) : (pa[k] - pb[k]);
    end
  end

  always_comb begin
    sum_next = R2_W'(sq[0]) + R2_W'(sq[1]) + R2_W'(sq[2]) + R2_W'(eps_sq);
    // coincident bodies with no softening count as one lsb
    if (sum_next == '0) begin
      sum_next = R2_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= side_next;
      side2 <= side1;
      for (int k = 0; k < 3; k++) begin
        sq[k] <= side1.mag[k] * side1.mag[k];
      end
      r2 <= sum_next;
      side <= side2;
    end
  end

endmodule

[design/spi_isqrt.sv]
// pipelined integer square root, one result bit per stage
module spi_isqrt import spi_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [R2_W-1:0] r2,
  input  side_t           in_side,
  output logic            out_valid,
  output logic [S_W-1:0]  s,
  output side_t           out_side
);

  logic                 v    [0:S_W];
  logic [SQ_IN_W-1:0]   nn   [0:S_W];
  logic [31:0]          rem  [0:S_W];
  logic [S_W-1:0]       root [0:S_W];
  side_t                sd   [0:S_W];

  assign v[0]    = in_valid;
  assign nn[0]   = {r2, 12'd0};
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign sd[0]   = in_side;

  for (genvar i = 0; i < S_W; i++) begin : g_stage
    logic [33:0] cur;
    logic [33:0] trial;
    logic        ge;

    assign cur   = {rem[i], nn[i][SQ_IN_W-1 -: 2]};
    assign trial = {1'b0, root[i], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nn[i+1]   <= nn[i] << 2;
        rem[i+1]  <= ge ? 32'(cur - trial) : cur[31:0];
        root[i+1] <= {root[i][S_W-2:0], ge};
        sd[i+1]   <= sd[i];
      end
    end
  end

  assign out_valid = v[S_W];
  assign s         = root[S_W];
  assign out_side  = sd[S_W];

endmodule

[design/spi_recip.sv]
// pipelined restoring division 2^62 / s, one quotient bit per stage
module spi_recip import spi_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [S_W-1:0] s,
  input  side_t          in_side,
  output logic           out_valid,
  output logic [R_W-1:0] r,
  output side_t          out_side
);

  logic           v   [0:R_W];
  logic [S_W-1:0] dv  [0:R_W];
  logic [31:0]    rem [0:R_W];
  logic [R_W-1:0] q   [0:R_W];
  side_t          sd  [0:R_W];

  assign v[0]   = in_valid;
  assign dv[0]  = s;
  assign rem[0] = RECIP_REM0;
  assign q[0]   = '0;
  assign sd[0]  = in_side;

  for (genvar i = 0; i < R_W; i++) begin : g_stage
    logic [32:0] cur;
    logic        ge;

    // dividend bits below the top are all zero
    assign cur = {rem[i], 1'b0};
    assign ge  = cur >= 33'(dv[i]);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[i+1]  <= dv[i];
        rem[i+1] <= ge ? 32'(cur - 33'(dv[i])) : cur[31:0];
        q[i+1]   <= {q[i][R_W-2:0], ge};
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign out_valid = v[R_W];
  assign r         = q[R_W];
  assign out_side  = sd[R_W];

endmodule

[design/spi_scale.sv]
// cube of the reciprocal, scaling by distance and charge, saturation
module spi_scale import spi_pkg::*; #(
  parameter int OUTPUT_FRACTION_BITS = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [R_W-1:0] r,
  input  side_t          in_side,
  output logic           out_valid,
  output incr_t          out_data
);

  localparam int PSH = 48 - OUTPUT_FRACTION_BITS;
  localparam int FSH = 120 - OUTPUT_FRACTION_BITS;

  logic [6:1] v;

  // stage 1
  side_t          sd1;
  logic [R_W-1:0] r1;
  logic [63:0]    ll1;
  logic [56:0]    lh1;
  logic [49:0]    hh1;
  logic [55:0]    p1l1, p2l1;
  logic [48:0]    p1h1, p2h1;
  // stage 2
  side_t            sd2;
  logic [R_W-1:0]   r2v;
  logic [R2P_W-1:0] rsq2;
  logic [OUT_W-1:0] pot1_2, pot2_2;
  // stage 3
  side_t            sd3;
  logic [OUT_W-1:0] pot1_3, pot2_3;
  logic [63:0]      pp3 [4][2];
  // stage 4
  side_t            sd4;
  logic [OUT_W-1:0] pot1_4, pot2_4;
  logic [R3_W-1:0]  r3_4;
  // stage 5
  side_t            sd5;
  logic [OUT_W-1:0] pot1_5, pot2_5;
  logic [55:0]      mp5 [3][6];
  // stage 6
  side_t            sd6;
  logic [OUT_W-1:0] pot1_6, pot2_6;
  logic [PROD_W-1:0] fp6 [3];

  logic [R2P_W-1:0]  rsq_next;
  logic [POT_W-1:0]  pot1_sum, pot2_sum, pot1_sh, pot2_sh;
  logic [31:0]       al [4];
  logic [31:0]       bl [2];
  logic [191:0]      r3_acc;
  logic [31:0]       cl [6];
  logic [223:0]      fp_acc [3];
  logic [PROD_W-1:0] fsh [3];
  logic [OUT_W-1:0]  fm [3];
  logic [OUT_W-1:0]  fa [3];
  logic [OUT_W-1:0]  fb [3];

  always_comb begin
    rsq_next = {hh1, 64'd0} + (R2P_W'(lh1) << 33) + R2P_W'(ll1);
    pot1_sum = (POT_W'(p2h1) << 32) + POT_W'(p2l1);
    pot2_sum = (POT_W'(p1h1) << 32) + POT_W'(p1l1);
    pot1_sh  = pot1_sum >> PSH;
    pot2_sh  = pot2_sum >> PSH;
  end

  always_comb begin
    al[0] = rsq2[31:0];
    al[1] = rsq2[63:32];
    al[2] = rsq2[95:64];
    al[3] = 32'(rsq2[R2P_W-1:96]);
    bl[0] = r2v[31:0];
    bl[1] = 32'(r2v[R_W-1:32]);
    r3_acc = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 2; j++) begin
        r3_acc = r3_acc + (192'(pp3[i][j]) << (32 * (i + j)));
      end
    end
    for (int j = 0; j < 5; j++) begin
      cl[j] = r3_4[32*j +: 32];
    end
    cl[5] = 32'(r3_4[R3_W-1:160]);
    for (int k = 0; k < 3; k++) begin
      fp_acc[k] = '0;
      for (int j = 0; j < 6; j++) begin
        fp_acc[k] = fp_acc[k] + (224'(mp5[k][j]) << (32 * j));
      end
    end
    for (int k = 0; k < 3; k++) begin
      fsh[k] = fp6[k] >> FSH;
      fm[k]  = (fsh[k] > PROD_W'(NEG_MAX)) ? NEG_MAX : fsh[k][OUT_W-1:0];
      fa[k]  = sgn_out(fm[k], sd6.neg[k]);
      fb[k]  = sgn_out(fm[k], ~sd6.neg[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v <= {v[5:1], in_valid};
      out_valid <= v[6];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd1  <= in_side;
      r1   <= r;
      ll1  <= r[31:0] * r[31:0];
      lh1  <= r[31:0] * r[R_W-1:32];
      hh1  <= r[R_W-1:32] * r[R_W-1:32];
      p1l1 <= in_side.q1 * r[31:0];
      p1h1 <= in_side.q1 * r[R_W-1:32];
      p2l1 <= in_side.q2 * r[31:0];
      p2h1 <= in_side.q2 * r[R_W-1:32];

      sd2    <= sd1;
      r2v    <= r1;
      rsq2   <= rsq_next;
      pot1_2 <= (pot1_sh > POT_W'(POS_MAX)) ? POS_MAX : pot1_sh[OUT_W-1:0];
      pot2_2 <= (pot2_sh > POT_W'(POS_MAX)) ? POS_MAX : pot2_sh[OUT_W-1:0];

      sd3    <= sd2;
      pot1_3 <= pot1_2;
      pot2_3 <= pot2_2;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 2; j++) begin
          pp3[i][j] <= al[i] * bl[j];
        end
      end

      sd4    <= sd3;
      pot1_4 <= pot1_3;
      pot2_4 <= pot2_3;
      r3_4   <= r3_acc[R3_W-1:0];

      sd5    <= sd4;
      pot1_5 <= pot1_4;
      pot2_5 <= pot2_4;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 6; j++) begin
          mp5[k][j] <= sd4.mag[k] * cl[j];
        end
      end

      sd6    <= sd5;
      pot1_6 <= pot1_5;
      pot2_6 <= pot2_5;
      for (int k = 0; k < 3; k++) begin
        fp6[k] <= fp_acc[k][PROD_W-1:0];
      end

      out_data.first_fx         <= fa[0];
      out_data.first_fy         <= fa[1];
      out_data.first_fz         <= fa[2];
      out_data.first_potential  <= pot1_6;
      out_data.second_fx        <= fb[0];
      out_data.second_fy        <= fb[1];
      out_data.second_fz        <= fb[2];
      out_data.second_potential <= pot2_6;
    end
  end

endmodule

[design/softened_pair_interaction_core.sv]
// each pair runs from input to result through the distance, sqrt, divide and scale pipelines
// throughput: one pair per cycle unless stalled; the 57-stage reciprocal divider sets the depth
// a stall on the output freezes every stage, nothing is dropped or repeated
// reset (rst, synchronous) clears all stage valid bits and loads the default softening
// configuration writes are taken at any time, cfg_ready is always high
module softened_pair_interaction_core import spi_pkg::*; #(
  parameter int OUTPUT_FRACTION_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pair_t             in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output incr_t             out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SOFT_W-1:0] cfg_data
);

  logic              en;
  logic [SOFT_W-1:0] softening;
  logic              f_valid, q_valid, d_valid;
  logic [R2_W-1:0]   f_r2;
  logic [S_W-1:0]    q_s;
  logic [R_W-1:0]    d_r;
  side_t             f_side, q_side, d_side;

  assign en        = ~out_valid | out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      softening <= SOFT_RESET;
    end else if (cfg_valid) begin
      softening <= cfg_data;
    end
  end

  spi_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid), .in_data(in_data),
    .eps_sq(softening), .out_valid(f_valid), .r2(f_r2), .side(f_side)
  );

  spi_isqrt u_isqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_valid), .r2(f_r2), .in_side(f_side),
    .out_valid(q_valid), .s(q_s), .out_side(q_side)
  );

  spi_recip u_recip (
    .clk(clk), .rst(rst), .en(en), .in_valid(q_valid), .s(q_s), .in_side(q_side),
    .out_valid(d_valid), .r(d_r), .out_side(d_side)
  );

  spi_scale #(.OUTPUT_FRACTION_BITS(OUTPUT_FRACTION_BITS)) u_scale (
    .clk(clk), .rst(rst), .en(en), .in_valid(d_valid), .r(d_r), .in_side(d_side),
    .out_valid(out_valid), .out_data(out_data)
  );

endmodule

[design/spi_checker.sv]
// port level checks for the softened pair interaction core
module spi_checker import spi_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input pair_t             in_data,
  input logic              out_valid,
  input logic              out_ready,
  input incr_t             out_data,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [SOFT_W-1:0] cfg_data
);

  // a result held back must stay until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // with no result waiting the pipe must take input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input refused with empty output");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");

  // potentials never negative
  a_pot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_data.first_potential[47] && !out_data.second_potential[47])
    else $error("negative potential");

  // x forces on the two bodies cancel unless saturated
  a_anti: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.first_fx != NEG_MAX && out_data.second_fx != NEG_MAX
    |-> OUT_W'(out_data.first_fx + out_data.second_fx) == '0)
    else $error("force pair not opposite");

endmodule

bind softened_pair_interaction_core spi_checker u_spi_checker (.*);

[verif/softened_pair_interaction_core_tb.sv]
// testbench for the softened pair interaction core: directed and random pairs against a predictor
`timescale 1ns / 1ps
module softened_pair_interaction_core_tb;
  import spi_pkg::*;

  localparam int FRAC = 24;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  pair_t             in_data;
  logic              out_valid;
  logic              out_ready;
  incr_t             out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [SOFT_W-1:0] cfg_data;

  logic [SOFT_W-1:0] soft_sq;
  incr_t             incr_q[$];
  int                fail_cnt;
  int                send_idle_pct;
  int                recv_idle_pct;

  softened_pair_interaction_core #(.OUTPUT_FRACTION_BITS(FRAC)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // bitwise integer square root, floor
  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [OUT_W-1:0] signed_incr(input logic [OUT_W-1:0] m, input logic neg);
    if (neg) return 48'd0 - m;
    return (m > POS_MAX) ? POS_MAX : m;
  endfunction

  function automatic incr_t pair_increments(input pair_t p);
    logic [2:0][COORD_W-1:0] a;
    logic [2:0][COORD_W-1:0] b;
    logic [2:0][COORD_W-1:0] mag;
    logic [2:0]              neg;
    logic [63:0]             r2sum;
    logic [63:0]             s;
    logic [63:0]             r;
    logic [191:0]            r3;
    logic [255:0]            prod;
    logic [127:0]            pot;
    logic [OUT_W-1:0]        m;
    logic [2:0][OUT_W-1:0]   f1;
    logic [2:0][OUT_W-1:0]   f2;
    incr_t                   res;
    a = {p.first_z, p.first_y, p.first_x};
    b = {p.second_z, p.second_y, p.second_x};
    r2sum = {16'd0, soft_sq};
    for (int k = 0; k < 3; k++) begin
      neg[k] = a[k] < b[k];
      mag[k] = neg[k] ? b[k] - a[k] : a[k] - b[k];
      r2sum  = r2sum + 64'(mag[k]) * 64'(mag[k]);
    end
    if (r2sum == 0) r2sum = 1;
    s  = root_floor(r2sum << 12);
    r  = (64'd1 << 62) / s;
    r3 = 192'(r) * 192'(r) * 192'(r);
    for (int k = 0; k < 3; k++) begin
      m = '0;
      if (mag[k] != 0) begin
        prod = (256'(r3) * 256'(mag[k])) >> (120 - FRAC);
        m = (prod > 256'(NEG_MAX)) ? NEG_MAX : prod[OUT_W-1:0];
      end
      f1[k] = signed_incr(m, neg[k]);
      f2[k] = signed_incr(m, !neg[k]);
    end
    res.first_fx = f1[0];
    res.first_fy = f1[1];
    res.first_fz = f1[2];
    res.second_fx = f2[0];
    res.second_fy = f2[1];
    res.second_fz = f2[2];
    pot = (128'(r) * 128'(p.second_charge)) >> (48 - FRAC);
    res.first_potential = (pot > 128'(POS_MAX)) ? POS_MAX : pot[OUT_W-1:0];
    pot = (128'(r) * 128'(p.first_charge)) >> (48 - FRAC);
    res.second_potential = (pot > 128'(POS_MAX)) ? POS_MAX : pot[OUT_W-1:0];
    return res;
  endfunction

  // valid stays high after acceptance until the sender idles or stops
  task automatic send_pair(input pair_t p);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    incr_q.push_back(pair_increments(p));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (incr_q.size() != 0) @(posedge clk);
    repeat (110) @(posedge clk);
  endtask

  task automatic write_softening(input logic [SOFT_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    soft_sq = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic pair_t random_pair();
    pair_t p;
    p = pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(3))
      0: begin
        // close bodies, large forces
        p.second_x = p.first_x + 24'($urandom_range(255));
        p.second_y = p.first_y - 24'($urandom_range(255));
        p.second_z = p.first_z + 24'($urandom_range(15));
      end
      1: begin
        p.second_x = p.first_x;
        p.second_y = p.first_y ^ 24'($urandom_range(4095));
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic test_directed();
    pair_t p;
    p = '0;
    send_pair(p);
    p = '1;
    send_pair(p);
    p = '0;
    p.first_x = '1;
    p.first_charge = '1;
    p.second_charge = 24'd1;
    send_pair(p);
    p = '0;
    p.second_y = '1;
    p.second_z = '1;
    p.first_charge = 24'h010000;
    send_pair(p);
    p = '1;
    p.first_z = 24'd0;
    send_pair(p);
    p = pair_t'({24'h800000, 24'h800000, 24'h800000, 24'hFFFFFF,
                 24'h800001, 24'h7FFFFF, 24'h800000, 24'hFFFFFF});
    send_pair(p);
    p = pair_t'({24'h123456, 24'h654321, 24'h0F0F0F, 24'h000001,
                 24'h123456, 24'h654321, 24'h0F0F0F, 24'hABCDEF});
    send_pair(p);
  endtask

  task automatic test_zero_softening();
    pair_t p;
    write_softening('0);
    // coincident bodies with no softening
    p = pair_t'({24'h400000, 24'h400000, 24'h400000, 24'hFFFFFF,
                 24'h400000, 24'h400000, 24'h400000, 24'h000100});
    send_pair(p);
    p.second_x = p.first_x + 24'd1;
    send_pair(p);
    p = '0;
    p.second_z = 24'd1;
    p.first_charge = 24'd7;
    send_pair(p);
    p = '1;
    p.first_x = 24'hFFFFFE;
    send_pair(p);
    for (int i = 0; i < 60; i++) send_pair(random_pair());
  endtask

  task automatic test_max_softening();
    write_softening('1);
    for (int i = 0; i < 60; i++) send_pair(random_pair());
  endtask

  task automatic test_random(input int sidle, input int ridle, input int n);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        // hold off until the pipeline is empty
        in_valid <= 1'b0;
        while (incr_q.size() != 0) @(posedge clk);
      end
      send_pair(random_pair());
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    fail_cnt = 0;
    soft_sq = SOFT_RESET;
    send_idle_pct = 26;
    recv_idle_pct = 69;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_zero_softening();
    test_max_softening();
    write_softening(SOFT_RESET);
    test_random(26, 69, 350);
    write_softening({$urandom, $urandom} & 48'h0000_FFFF_FFFF);
    test_random(69, 26, 350);
    write_softening(48'd1);
    test_random(0, 0, 400);
    drain();
    if (fail_cnt == 0) begin
      $display("softened_pair_interaction_core_tb passed");
    end else begin
      $display("softened_pair_interaction_core_tb failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    incr_t want;
    if (!rst && out_valid && out_ready) begin
      if (incr_q.size() == 0) begin
        $error("result with no pair outstanding");
        fail_cnt++;
      end else begin
        want = incr_q.pop_front();
        if (out_data.first_fx !== want.first_fx) begin
          $error("first_fx exp %h got %h", want.first_fx, out_data.first_fx);
          fail_cnt++;
        end
        if (out_data.first_fy !== want.first_fy) begin
          $error("first_fy exp %h got %h", want.first_fy, out_data.first_fy);
          fail_cnt++;
        end
        if (out_data.first_fz !== want.first_fz) begin
          $error("first_fz exp %h got %h", want.first_fz, out_data.first_fz);
          fail_cnt++;
        end
        if (out_data.first_potential !== want.first_potential) begin
          $error("first_potential exp %h got %h", want.first_potential,
                 out_data.first_potential);
          fail_cnt++;
        end
        if (out_data.second_fx !== want.second_fx) begin
          $error("second_fx exp %h got %h", want.second_fx, out_data.second_fx);
          fail_cnt++;
        end
        if (out_data.second_fy !== want.second_fy) begin
          $error("second_fy exp %h got %h", want.second_fy, out_data.second_fy);
          fail_cnt++;
        end
        if (out_data.second_fz !== want.second_fz) begin
          $error("second_fz exp %h got %h", want.second_fz, out_data.second_fz);
          fail_cnt++;
        end
        if (out_data.second_potential !== want.second_potential) begin
          $error("second_potential exp %h got %h", want.second_potential,
                 out_data.second_potential);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("softened_pair_interaction_core_tb failed");
    $finish;
  end

endmodule
